// ===== hdl/urc_pkg.sv =====
`timescale 1ns / 1ps

package urc_pkg;

  // Field widths.
  localparam int unsigned DistW   = 9;
  localparam int unsigned TimeoutW = 16;
  localparam int unsigned GapW    = 20;
  localparam int unsigned TickW   = 20;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 20;

  // Timing constants in microsecond ticks.
  localparam int unsigned UsPerCm       = 58;
  localparam int unsigned TriggerLowUs  = 4;
  localparam int unsigned TriggerHighUs = 10;
  localparam int unsigned RemW          = $clog2(UsPerCm);

  // Status codes.
  localparam logic [StatusW-1:0] ST_OK           = 2'd0;
  localparam logic [StatusW-1:0] ST_BUSY         = 2'd1;
  localparam logic [StatusW-1:0] ST_PING_TIMEOUT = 2'd2;
  localparam logic [StatusW-1:0] ST_ECHO_TIMEOUT = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_DIST  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEAR_THR  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PING_TOUT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_GAP       = 3'd3;

  // Configuration register reset values.
  localparam logic [DistW-1:0]    MaxDistRst  = 9'd400;
  localparam logic [DistW-1:0]    NearThrRst  = 9'd10;
  localparam logic [TimeoutW-1:0] PingToutRst = 16'd6000;
  localparam logic [GapW-1:0]     GapRst      = 20'd150000;

  typedef struct packed {
    logic [DistW-1:0]    max_range_cm;
    logic [DistW-1:0]    near_threshold_cm;
    logic [TimeoutW-1:0] ping_timeout_us;
    logic [GapW-1:0]     repeat_gap_us;
  } urc_cfg_t;

  typedef struct packed {
    logic               trigger_out;
    logic               measure_done;
    logic [StatusW-1:0] status;
    logic [DistW-1:0]   distance_cm;
    logic               near_event;
  } urc_res_t;

endpackage

// ===== hdl/urc_cfg_regs.sv =====
`timescale 1ns / 1ps

module urc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [urc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [urc_pkg::CfgDataW-1:0]  cfg_data_i,
  output urc_pkg::urc_cfg_t             cfg_o
);
  import urc_pkg::*;

  urc_cfg_t cfg_q, cfg_d;

  // Decode a register write; unknown indexes are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MAX_DIST:  cfg_d.max_range_cm      = cfg_data_i[DistW-1:0];
        CFG_NEAR_THR:  cfg_d.near_threshold_cm = cfg_data_i[DistW-1:0];
        CFG_PING_TOUT: cfg_d.ping_timeout_us   = cfg_data_i[TimeoutW-1:0];
        CFG_GAP:       cfg_d.repeat_gap_us     = cfg_data_i[GapW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_range_cm      <= MaxDistRst;
      cfg_q.near_threshold_cm <= NearThrRst;
      cfg_q.ping_timeout_us   <= PingToutRst;
      cfg_q.repeat_gap_us     <= GapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/urc_seq.sv =====
`timescale 1ns / 1ps

module urc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              tick_i,
  input  logic              echo_i,
  input  urc_pkg::urc_cfg_t cfg_i,
  output urc_pkg::urc_res_t res_o
);
  import urc_pkg::*;

  localparam logic [2:0] PH_TRIG_LOW  = 3'd0;
  localparam logic [2:0] PH_TRIG_HIGH = 3'd1;
  localparam logic [2:0] PH_CHECK     = 3'd2;
  localparam logic [2:0] PH_WAIT_RISE = 3'd3;
  localparam logic [2:0] PH_MEASURE   = 3'd4;
  localparam logic [2:0] PH_GAP       = 3'd5;

  localparam logic [TickW-1:0] TrigLowTicks  = TickW'(TriggerLowUs);
  localparam logic [TickW-1:0] TrigHighTicks = TickW'(TriggerHighUs);
  localparam logic [RemW-1:0]  RemLast       = RemW'(UsPerCm - 1);

  logic [2:0]         phase_q, phase_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic               armed_q, armed_d;
  logic [DistW-1:0]   dist_q, dist_d;
  logic [StatusW-1:0] status_q, status_d;
  // Running quotient and remainder of the echo width by UsPerCm.
  logic [DistW-1:0]   cm_q, cm_d;
  logic [RemW-1:0]    rem_q, rem_d;

  logic [TickW-1:0]   tick_inc;
  logic [TickW-1:0]   low_base;
  logic [TickW-1:0]   low_inc;
  logic [TickW-1:0]   limit;
  logic               rem_wrap;
  logic [DistW-1:0]   cm_next;
  logic               finish;
  logic [StatusW-1:0] fin_code;
  logic               trig;
  logic               near;

  assign tick_inc = tick_q + 1'b1;
  assign low_base = (phase_q == PH_TRIG_LOW) ? tick_q : '0;
  assign low_inc  = low_base + 1'b1;
  assign limit    = TickW'(cfg_i.max_range_cm) * TickW'(UsPerCm);
  assign rem_wrap = (rem_q == RemLast);
  assign cm_next  = cm_q + DistW'(rem_wrap);

  // Phase sequencing for one tick.
  always_comb begin
    phase_d  = phase_q;
    tick_d   = tick_q;
    cm_d     = cm_q;
    rem_d    = rem_q;
    finish   = 1'b0;
    fin_code = ST_OK;
    trig     = 1'b0;
    case (phase_q)
      PH_TRIG_HIGH: begin
        trig   = 1'b1;
        tick_d = tick_inc;
        if (tick_inc >= TrigHighTicks) begin
          phase_d = PH_CHECK;
          tick_d  = '0;
        end
      end
      PH_CHECK: begin
        if (echo_i) begin
          finish   = 1'b1;
          fin_code = ST_BUSY;
        end else begin
          phase_d = PH_WAIT_RISE;
          tick_d  = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo_i) begin
          phase_d = PH_MEASURE;
          tick_d  = '0;
          cm_d    = '0;
          rem_d   = '0;
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= TickW'(cfg_i.ping_timeout_us)) begin
            finish   = 1'b1;
            fin_code = ST_PING_TIMEOUT;
          end
        end
      end
      PH_MEASURE: begin
        tick_d = tick_inc;
        cm_d   = cm_next;
        rem_d  = rem_wrap ? '0 : rem_q + 1'b1;
        if (!echo_i) begin
          finish   = 1'b1;
          fin_code = ST_OK;
        end else if (tick_inc >= limit) begin
          finish   = 1'b1;
          fin_code = ST_ECHO_TIMEOUT;
        end
      end
      PH_GAP: begin
        tick_d = tick_inc;
        if (tick_inc >= cfg_i.repeat_gap_us) begin
          phase_d = PH_TRIG_LOW;
          tick_d  = '0;
        end
      end
      default: begin
        // Trigger low phase; unused codes restart here with a fresh count.
        phase_d = PH_TRIG_LOW;
        tick_d  = low_inc;
        if (low_inc >= TrigLowTicks) begin
          phase_d = PH_TRIG_HIGH;
          tick_d  = '0;
        end
      end
    endcase
  end

  // Completion of an attempt: status, distance and near event.
  always_comb begin
    status_d = status_q;
    dist_d   = dist_q;
    armed_d  = armed_q;
    near     = 1'b0;
    if (finish) begin
      status_d = fin_code;
      if (fin_code == ST_OK) begin
        dist_d = cm_next;
        if ((cm_next < cfg_i.near_threshold_cm) && armed_q) begin
          near    = 1'b1;
          armed_d = 1'b0;
        end
        if (cm_next > cfg_i.near_threshold_cm) begin
          armed_d = 1'b1;
        end
      end
    end
  end

  logic [2:0]       phase_fin;
  logic [TickW-1:0] tick_fin;

  assign phase_fin = finish ? ((cfg_i.repeat_gap_us == '0) ? PH_TRIG_LOW : PH_GAP) : phase_d;
  assign tick_fin  = finish ? '0 : tick_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_TRIG_LOW;
      tick_q   <= '0;
      armed_q  <= 1'b1;
      dist_q   <= '0;
      status_q <= ST_OK;
      cm_q     <= '0;
      rem_q    <= '0;
    end else if (tick_i) begin
      phase_q  <= phase_fin;
      tick_q   <= tick_fin;
      armed_q  <= armed_d;
      dist_q   <= dist_d;
      status_q <= status_d;
      cm_q     <= cm_d;
      rem_q    <= rem_d;
    end
  end

  // Result of this tick, registered by the output stage.
  always_comb begin
    res_o.trigger_out  = trig;
    res_o.measure_done = finish;
    res_o.status       = status_d;
    res_o.distance_cm  = dist_d;
    res_o.near_event   = near;
  end

endmodule

// ===== hdl/ultrasonic_range_controller.sv =====
`timescale 1ns / 1ps

// Ultrasonic range controller for a trigger/echo ranging sensor.
// Each transfer on the input channel is one microsecond tick carrying the
// sampled echo pin level; each tick yields exactly one transfer on the output
// channel with the trigger level to drive, a done pulse, the status of the
// latest attempt, the last good distance in centimeters and the near event.
// The block takes one tick per cycle while the receiver is ready. A result
// is held in the output register and appears in the cycle after its tick is
// transferred in. The distance is kept as a running quotient during the
// echo, so no divider is needed.
// The configuration channel writes register 0 max distance, 1 near threshold,
// 2 ping timeout and 3 repeat gap; it is always ready and should be used only
// while the block is idle.
// Reset puts the sequencer at the start of the trigger low phase with the near
// event armed, and loads the register defaults. When the receiver stalls, the
// held result stays put and the input channel stops accepting ticks until
// that result is transferred.
module ultrasonic_range_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          echo_level_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          trigger_out_o,
  output logic                          measure_done_o,
  output logic [urc_pkg::StatusW-1:0]   status_o,
  output logic [urc_pkg::DistW-1:0]     distance_cm_o,
  output logic                          near_event_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [urc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [urc_pkg::CfgDataW-1:0]  cfg_data_i
);
  import urc_pkg::*;

  urc_cfg_t cfg;
  urc_res_t res;
  urc_res_t res_q;
  logic     out_valid_q, out_valid_d;
  logic     in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_xfer     = in_valid_i && in_ready_o;

  urc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  urc_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (in_xfer),
    .echo_i (echo_level_i),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Output register: loads on every input transfer, drains on output transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign trigger_out_o  = res_q.trigger_out;
  assign measure_done_o = res_q.measure_done;
  assign status_o       = res_q.status;
  assign distance_cm_o  = res_q.distance_cm;
  assign near_event_o   = res_q.near_event;

  // A near event only comes with a successful measurement.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && near_event_o |-> measure_done_o && (status_o == ST_OK))
    else $error("near event without a good measurement");

  // The trigger is never driven on the tick an attempt finishes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && trigger_out_o |-> !measure_done_o)
    else $error("trigger high on a finishing tick");

  // Every accepted tick produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted tick without a result");

  // With no held result the input side must be open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while output is empty");

endmodule
